[rtl/rnpr_pkg.sv]
// ============================================================================
// rnpr_pkg - ranged nearest point ring package
// Shared widths, operation codes and sequencer states.
// ============================================================================
`default_nettype none

package rnpr_pkg;

    localparam int SLOT_W         = 8;
    localparam int FIELD_W        = 16;
    localparam int COUNT_W        = 9;
    localparam int DIST_W         = 33;
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_ONES = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/ranged_nearest_point_ring_top.sv]
// ============================================================================
// ranged_nearest_point_ring_top - nearest stored point within an index ring
// Point store with a scanning nearest-neighbor query over one multiplier.
// ============================================================================
// A load beat (start with busy low, operation 0) writes one point in the
// accept cycle and leaves busy low, so the next beat may follow at once. A
// query beat raises busy and scans slots 0 to point_count-1 one by one
// (memory read, difference, x square, y square, compare) on one shared
// multiplier, then shows the result for one cycle on o_done. The receiver
// cannot stall; o_done is a one-cycle strobe. The result ports then hold
// until the next query is accepted, but o_range_error follows later loads.
`default_nettype none

module ranged_nearest_point_ring_top #(
    parameter int MAX_POINTS = rnpr_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = rnpr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_operation,
    input  wire logic        [rnpr_pkg::SLOT_W-1:0]  i_point_slot,
    input  wire logic signed [rnpr_pkg::FIELD_W-1:0] i_pos_x,
    input  wire logic signed [rnpr_pkg::FIELD_W-1:0] i_pos_y,
    input  wire logic        [rnpr_pkg::SLOT_W-1:0]  i_ring_first,
    input  wire logic        [rnpr_pkg::SLOT_W-1:0]  i_ring_last,
    output logic                                   o_done,
    output logic             [rnpr_pkg::SLOT_W-1:0]  o_nearest_slot,
    output logic             [rnpr_pkg::SLOT_W-1:0]  o_next_slot,
    output logic             [rnpr_pkg::SLOT_W-1:0]  o_prev_slot,
    output logic             [rnpr_pkg::DIST_W-1:0]  o_best_dist_sq,
    output logic                                   o_range_error
);

    localparam int CB    = COORD_BITS;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW    = rnpr_pkg::SLOT_W;
    localparam int NW    = rnpr_pkg::COUNT_W;
    localparam int DW    = rnpr_pkg::DIST_W;
    localparam int FW    = rnpr_pkg::FIELD_W;
    localparam int SUM_W = 2 * CB + 1;
    localparam int CMP_W = (SUM_W > DW) ? SUM_W : DW;

    rnpr_pkg::t_state r_state, n_state;

    logic [2*CB-1:0] r_mem [MAX_POINTS];
    logic [2*CB-1:0] r_rd;

    logic [NW-1:0]        r_count, n_count;
    logic signed [CB-1:0] r_qx, n_qx, r_qy, n_qy;
    logic [SW-1:0]        r_first, n_first, r_last, n_last;
    logic [NW-1:0]        r_idx, n_idx;
    logic [CB-1:0]        r_dx, n_dx, r_dy, n_dy;
    logic [2*CB-1:0]      r_sx, n_sx;
    logic [DW-1:0]        r_dist, n_dist;
    logic [SW-1:0]        r_best, n_best;
    logic [DW-1:0]        r_best_d, n_best_d;

    logic                 w_accept;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [CB+FW-1:0]     w_ext_x, w_ext_y;
    logic signed [CB-1:0] w_in_x, w_in_y;
    logic signed [CB-1:0] w_rd_x, w_rd_y;
    logic signed [CB:0]   w_diff_x, w_diff_y;
    logic [CB:0]          w_abs_x, w_abs_y;
    logic [CB-1:0]        w_mul_a;
    logic [2*CB-1:0]      w_prod;
    logic [SUM_W-1:0]     w_sum;
    logic [CMP_W-1:0]     w_sum_x, w_ones_x;
    logic                 w_in_ring;
    logic [NW-1:0]        w_idx_inc;
    logic [NW-1:0]        w_slot_inc;

    assign w_accept = start && !busy;

    assign w_ext_x = {{CB{1'b0}}, i_pos_x};
    assign w_ext_y = {{CB{1'b0}}, i_pos_y};
    assign w_in_x  = w_ext_x[CB-1:0];
    assign w_in_y  = w_ext_y[CB-1:0];

    assign w_wr_en    = w_accept && (i_operation == rnpr_pkg::OP_LOAD)
                        && (32'(i_point_slot) < MAX_POINTS);
    assign w_wr_addr  = AW'(i_point_slot);
    assign w_slot_inc = NW'(i_point_slot) + NW'(1);

    assign w_rd_x   = r_rd[2*CB-1:CB];
    assign w_rd_y   = r_rd[CB-1:0];
    assign w_diff_x = {w_rd_x[CB-1], w_rd_x} - {r_qx[CB-1], r_qx};
    assign w_diff_y = {w_rd_y[CB-1], w_rd_y} - {r_qy[CB-1], r_qy};
    assign w_abs_x  = w_diff_x[CB] ? (~w_diff_x + 1'b1) : w_diff_x;
    assign w_abs_y  = w_diff_y[CB] ? (~w_diff_y + 1'b1) : w_diff_y;

    assign w_mul_a  = (r_state == rnpr_pkg::S_SQX) ? r_dx : r_dy;
    assign w_prod   = w_mul_a * w_mul_a;
    assign w_sum    = {1'b0, r_sx} + {1'b0, w_prod};
    assign w_sum_x  = CMP_W'(w_sum);
    assign w_ones_x = CMP_W'(rnpr_pkg::DIST_ONES);

    assign w_in_ring = (r_idx >= NW'(r_first)) && (r_idx <= NW'(r_last));
    assign w_idx_inc = r_idx + NW'(1);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {w_in_x, w_in_y};
        end
        r_rd <= r_mem[AW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnpr_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_first  <= n_first;
        r_last   <= n_last;
        r_idx    <= n_idx;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sx     <= n_sx;
        r_dist   <= n_dist;
        r_best   <= n_best;
        r_best_d <= n_best_d;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_first  = r_first;
        n_last   = r_last;
        n_idx    = r_idx;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx     = r_sx;
        n_dist   = r_dist;
        n_best   = r_best;
        n_best_d = r_best_d;
        busy     = (r_state != rnpr_pkg::S_IDLE);
        o_done   = 1'b0;

        case (r_state)
            rnpr_pkg::S_IDLE: begin
                if (w_wr_en && (w_slot_inc > r_count)) begin
                    n_count = w_slot_inc;
                end
                if (w_accept && (i_operation == rnpr_pkg::OP_QUERY)) begin
                    n_qx     = w_in_x;
                    n_qy     = w_in_y;
                    n_first  = i_ring_first;
                    n_last   = i_ring_last;
                    n_idx    = '0;
                    n_best   = '0;
                    n_best_d = rnpr_pkg::DIST_ONES;
                    n_state  = (r_count == '0) ? rnpr_pkg::S_DONE : rnpr_pkg::S_READ;
                end
            end
            rnpr_pkg::S_READ: begin
                n_state = rnpr_pkg::S_DIFF;
            end
            rnpr_pkg::S_DIFF: begin
                n_dx    = w_abs_x[CB-1:0];
                n_dy    = w_abs_y[CB-1:0];
                n_state = rnpr_pkg::S_SQX;
            end
            rnpr_pkg::S_SQX: begin
                n_sx    = w_prod;
                n_state = rnpr_pkg::S_SQY;
            end
            rnpr_pkg::S_SQY: begin
                n_dist  = (w_sum_x > w_ones_x) ? rnpr_pkg::DIST_ONES : DW'(w_sum);
                n_state = rnpr_pkg::S_CMP;
            end
            rnpr_pkg::S_CMP: begin
                if (w_in_ring && (r_best_d >= r_dist)) begin
                    n_best   = r_idx[SW-1:0];
                    n_best_d = r_dist;
                end
                n_idx   = w_idx_inc;
                n_state = (w_idx_inc >= r_count) ? rnpr_pkg::S_DONE : rnpr_pkg::S_READ;
            end
            rnpr_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = rnpr_pkg::S_IDLE;
            end
            default: begin
                n_state = rnpr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_nearest_slot = r_best;
    assign o_best_dist_sq = r_best_d;
    assign o_next_slot    = (r_best >= r_last) ? r_first : r_best + SW'(1);
    assign o_prev_slot    = (r_best <= r_first) ? r_last : r_best - SW'(1);
    assign o_range_error  = (NW'(r_first) >= r_count) || (NW'(r_last) >= r_count);

endmodule

`default_nettype wire

[rtl/rnpr_checker.sv]
// ============================================================================
// rnpr_checker - port-level checks for the nearest point ring
// Watches the command handshake and the result strobe over time.
// ============================================================================
`default_nettype none

module rnpr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_operation,
    input wire logic o_done
);

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == rnpr_pkg::OP_LOAD) |=> !busy)
        else $error("load beat raised busy");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == rnpr_pkg::OP_LOAD) |=> !o_done)
        else $error("load beat produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == rnpr_pkg::OP_QUERY) |=> busy)
        else $error("query beat did not raise busy");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("busy held after result strobe");

endmodule

bind ranged_nearest_point_ring_top rnpr_checker u_rnpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_done      (o_done)
);

`default_nettype wire

[tb/testbench.sv]
// ============================================================================
// testbench - ranged nearest point ring
// Drives load and query beats through the start/busy handshake and checks
// every o_done result against a fixed answer from the directed table or a
// local nearest-in-ring predictor. A short table of directed beats comes
// first, then weighted random traffic that grows the store toward all 256.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    localparam int N_RANDOM     = 926;
    localparam int SMALL_PHASE  = 600;
    localparam int SMALL_CAP    = 16;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_LIMIT  = 3000;
    localparam int SETTLE_TIME  = 1300;

    typedef struct packed {
        logic [rnpr_pkg::SLOT_W-1:0] nearest_slot;
        logic [rnpr_pkg::SLOT_W-1:0] next_slot;
        logic [rnpr_pkg::SLOT_W-1:0] prev_slot;
        logic [rnpr_pkg::DIST_W-1:0] best_dist_sq;
        logic                        range_error;
    } t_ring_answer;

    typedef struct packed {
        logic                                op;
        logic        [rnpr_pkg::SLOT_W-1:0]  slot;
        logic signed [rnpr_pkg::FIELD_W-1:0] x;
        logic signed [rnpr_pkg::FIELD_W-1:0] y;
        logic        [rnpr_pkg::SLOT_W-1:0]  first;
        logic        [rnpr_pkg::SLOT_W-1:0]  last;
        logic                                fixed_want;
        t_ring_answer                        want;
    } t_stim_row;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                start        = 1'b0;
    logic                                busy;
    logic                                i_operation  = rnpr_pkg::OP_LOAD;
    logic        [rnpr_pkg::SLOT_W-1:0]  i_point_slot = '0;
    logic signed [rnpr_pkg::FIELD_W-1:0] i_pos_x      = '0;
    logic signed [rnpr_pkg::FIELD_W-1:0] i_pos_y      = '0;
    logic        [rnpr_pkg::SLOT_W-1:0]  i_ring_first = '0;
    logic        [rnpr_pkg::SLOT_W-1:0]  i_ring_last  = '0;
    logic                                o_done;
    logic        [rnpr_pkg::SLOT_W-1:0]  o_nearest_slot;
    logic        [rnpr_pkg::SLOT_W-1:0]  o_next_slot;
    logic        [rnpr_pkg::SLOT_W-1:0]  o_prev_slot;
    logic        [rnpr_pkg::DIST_W-1:0]  o_best_dist_sq;
    logic                                o_range_error;

    logic signed [rnpr_pkg::FIELD_W-1:0] stored_x [rnpr_pkg::MAX_POINTS_DEF];
    logic signed [rnpr_pkg::FIELD_W-1:0] stored_y [rnpr_pkg::MAX_POINTS_DEF];
    int                                  loaded_count = 0;
    t_ring_answer                        pending_answers [$];
    int                                  mismatch_count = 0;
    t_ring_answer                        oldest_answer;

    t_stim_row directed_rows [$] = '{
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0,   1'b1,
          '{8'd0, 8'd0, 8'd0, rnpr_pkg::DIST_ONES, 1'b1}},
        '{rnpr_pkg::OP_QUERY, 8'd0,   -16'sd1,     -16'sd1,     8'd255, 8'd0,   1'b1,
          '{8'd0, 8'd255, 8'd0, rnpr_pkg::DIST_ONES, 1'b1}},
        '{rnpr_pkg::OP_LOAD,  8'd0,   16'sh7FFF,   16'sh7FFF,   8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd1,   16'sh8000,   16'sh8000,   8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd2,   16'sd0,      16'sd0,      8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd3,   16'sh8000,   16'sh7FFF,   8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd4,   16'sh7FFF,   16'sh8000,   8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd255, 16'sd0,      16'sd0,      8'd0,   8'd5,   1'b1,
          '{8'd5, 8'd0, 8'd4, 33'd0, 1'b0}},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sh8000,   16'sh8000,   8'd0,   8'd0,   1'b1,
          '{8'd0, 8'd0, 8'd0, 33'd8589672450, 1'b0}},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sh7FFF,   16'sh7FFF,   8'd1,   8'd1,   1'b1,
          '{8'd1, 8'd1, 8'd1, 33'd8589672450, 1'b0}},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd4,   8'd2,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd100,    -16'sd100,   8'd2,   8'd200, 1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd200, 8'd3,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd12345,  -16'sd2222,  8'd3,   8'd3,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd6,   16'sd1,      -16'sd1,     8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd7,   -16'sd1,     16'sd1,      8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd0,   8'd7,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd6,   8'd7,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   -16'sd1,     -16'sd1,     8'd0,   8'd255, 1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sd0,      16'sd0,      8'd255, 8'd255, 1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sh8000,   16'sh7FFF,   8'd0,   8'd7,   1'b0, '0},
        '{rnpr_pkg::OP_LOAD,  8'd7,   16'sh7FFF,   16'sh8000,   8'd0,   8'd0,   1'b0, '0},
        '{rnpr_pkg::OP_QUERY, 8'd0,   16'sh7FFF,   16'sh8000,   8'd0,   8'd7,   1'b0, '0}
    };

    ranged_nearest_point_ring_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_point_slot   (i_point_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_ring_first   (i_ring_first),
        .i_ring_last    (i_ring_last),
        .o_done         (o_done),
        .o_nearest_slot (o_nearest_slot),
        .o_next_slot    (o_next_slot),
        .o_prev_slot    (o_prev_slot),
        .o_best_dist_sq (o_best_dist_sq),
        .o_range_error  (o_range_error)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_ring_answer nearest_in_ring(
        logic signed [rnpr_pkg::FIELD_W-1:0] qx,
        logic signed [rnpr_pkg::FIELD_W-1:0] qy,
        logic [rnpr_pkg::SLOT_W-1:0] first,
        logic [rnpr_pkg::SLOT_W-1:0] last);
        t_ring_answer answer;
        longint       ones;
        longint       dx;
        longint       dy;
        longint       d;
        longint       best_d;
        int           best;
        int           f;
        int           l;
        ones   = longint'(rnpr_pkg::DIST_ONES);
        best_d = ones;
        best   = 0;
        f      = int'(first);
        l      = int'(last);
        for (int i = 0; i < loaded_count; i++) begin
            if (i >= f && i <= l) begin
                dx = longint'(stored_x[i]) - longint'(qx);
                dy = longint'(stored_y[i]) - longint'(qy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                d = dx * dx + dy * dy;
                if (d > ones) d = ones;
                if (best_d >= d) begin
                    best_d = d;
                    best   = i;
                end
            end
        end
        answer.nearest_slot = rnpr_pkg::SLOT_W'(best);
        answer.next_slot    = (best >= l) ? first : rnpr_pkg::SLOT_W'(best + 1);
        answer.prev_slot    = (best <= f) ? last : rnpr_pkg::SLOT_W'(best - 1);
        answer.best_dist_sq = rnpr_pkg::DIST_W'(best_d);
        answer.range_error  = (f >= loaded_count) || (l >= loaded_count);
        return answer;
    endfunction

    function automatic logic signed [rnpr_pkg::FIELD_W-1:0] pick_coord(int kind);
        logic signed [rnpr_pkg::FIELD_W-1:0] value;
        if (kind < 4) begin
            case ($urandom_range(0, 3))
                0:       value = 16'sh8000;
                1:       value = 16'sh7FFF;
                2:       value = -16'sd1;
                default: value = 16'sd0;
            endcase
        end else if (kind < 6) begin
            value = rnpr_pkg::FIELD_W'(int'($urandom_range(0, 16)) - 8);
        end else begin
            value = rnpr_pkg::FIELD_W'($urandom);
        end
        return value;
    endfunction

    // present one beat at a falling edge, hold until accepted, then advance
    task automatic present_beat(input t_stim_row row);
        start        <= 1'b1;
        i_operation  <= row.op;
        i_point_slot <= row.slot;
        i_pos_x      <= row.x;
        i_pos_y      <= row.y;
        i_ring_first <= row.first;
        i_ring_last  <= row.last;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (row.op == rnpr_pkg::OP_QUERY) begin
            if (row.fixed_want)
                pending_answers = {pending_answers, row.want};
            else
                pending_answers = {pending_answers,
                                   nearest_in_ring(row.x, row.y, row.first, row.last)};
        end else begin
            stored_x[row.slot] = row.x;
            stored_y[row.slot] = row.y;
            if (int'(row.slot) + 1 > loaded_count) loaded_count = int'(row.slot) + 1;
        end
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input bit allowed);
        if (allowed && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result slot %0d dist %0d", $time,
                             o_nearest_slot, o_best_dist_sq);
                mismatch_count++;
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (o_nearest_slot !== oldest_answer.nearest_slot ||
                    o_next_slot !== oldest_answer.next_slot ||
                    o_prev_slot !== oldest_answer.prev_slot ||
                    o_best_dist_sq !== oldest_answer.best_dist_sq ||
                    o_range_error !== oldest_answer.range_error) begin
                    if (mismatch_count < 10)
                        $display({"%0t: mismatch want near %0d next %0d prev %0d dist %0d ",
                                  "err %0d, got near %0d next %0d prev %0d dist %0d err %0d"},
                                 $time, oldest_answer.nearest_slot, oldest_answer.next_slot,
                                 oldest_answer.prev_slot, oldest_answer.best_dist_sq,
                                 oldest_answer.range_error, o_nearest_slot, o_next_slot,
                                 o_prev_slot, o_best_dist_sq, o_range_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int        cap;
        int        mode;
        int        a;
        int        b;
        int        j;
        int        waited;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            pause_sender(1'b1);
            present_beat(directed_rows[n]);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            row = '0;
            cap = (k < SMALL_PHASE) ? SMALL_CAP : rnpr_pkg::MAX_POINTS_DEF;
            if (k < SMALL_PHASE)
                row.op = (loaded_count == 0 || $urandom_range(0, 1) == 0) ?
                         rnpr_pkg::OP_LOAD : rnpr_pkg::OP_QUERY;
            else if (loaded_count < rnpr_pkg::MAX_POINTS_DEF)
                row.op = ($urandom_range(0, 3) != 0) ? rnpr_pkg::OP_LOAD : rnpr_pkg::OP_QUERY;
            else
                row.op = $urandom_range(0, 1) ? rnpr_pkg::OP_QUERY : rnpr_pkg::OP_LOAD;

            mode = $urandom_range(0, 9);
            j    = (loaded_count > 0) ? $urandom_range(0, loaded_count - 1) : 0;
            if (mode < 2 && loaded_count > 0) begin
                row.x = stored_x[j];
                row.y = stored_y[j];
            end else begin
                row.x = pick_coord(mode);
                row.y = pick_coord(mode);
            end

            if (row.op == rnpr_pkg::OP_LOAD) begin
                if (loaded_count == 0 ||
                    (loaded_count < cap &&
                     (k >= SMALL_PHASE ? $urandom_range(0, 6) != 0
                                       : $urandom_range(0, 2) == 0)))
                    row.slot = rnpr_pkg::SLOT_W'(loaded_count);
                else
                    row.slot = rnpr_pkg::SLOT_W'($urandom_range(0, loaded_count - 1));
                row.first = rnpr_pkg::SLOT_W'($urandom);
                row.last  = rnpr_pkg::SLOT_W'($urandom);
            end else begin
                row.slot = rnpr_pkg::SLOT_W'($urandom);
                a    = $urandom_range(0, loaded_count - 1);
                b    = $urandom_range(0, loaded_count - 1);
                mode = $urandom_range(0, 9);
                if (mode < 6) begin
                    row.first = rnpr_pkg::SLOT_W'((a < b) ? a : b);
                    row.last  = rnpr_pkg::SLOT_W'((a < b) ? b : a);
                end else if (mode == 6) begin
                    row.first = rnpr_pkg::SLOT_W'((a < b) ? b : a);
                    row.last  = rnpr_pkg::SLOT_W'((a < b) ? a : b);
                end else if (mode == 7) begin
                    row.first = rnpr_pkg::SLOT_W'($urandom);
                    row.last  = rnpr_pkg::SLOT_W'($urandom);
                end else if (mode == 8) begin
                    row.first = rnpr_pkg::SLOT_W'(a);
                    row.last  = rnpr_pkg::SLOT_W'($urandom);
                end else begin
                    row.first = '0;
                    row.last  = rnpr_pkg::SLOT_W'(loaded_count - 1);
                end
            end
            pause_sender(k < N_RANDOM - QUIET_TAIL);
            present_beat(row);
        end

        start  <= 1'b0;
        waited = 0;
        while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_TIME) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
